/* sv/esbd_pkg.sv */
`timescale 1ns / 1ps
// constants and helpers for the epoch seconds to bcd date/time converter
// no dependencies; imported by epoch_seconds_to_bcd_datetime

package esbd_pkg;

   localparam int EPOCH_W  = 32;
   localparam int DAYS_W   = 16;
   localparam int TOD_W    = 17;

   // first second after 2099-12-31 23:59:59
   localparam logic [EPOCH_W-1:0] LIMIT_SECONDS = 32'd4102444800;

   // days = (secs >> 7) / 675, exact ceiling reciprocal for 25-bit operands
   localparam int DAY_SHIFT = 35;
   localparam longint unsigned DAY_RECIP_L = ((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675;
   localparam logic [25:0] DAY_RECIP = DAY_RECIP_L[25:0];

   // four-year cycles = days / 1461 for 16-bit operands
   localparam int CYC_SHIFT = 27;
   localparam longint unsigned CYC_RECIP_L = ((64'd1 << CYC_SHIFT) + 64'd1460) / 64'd1461;
   localparam logic [16:0] CYC_RECIP = CYC_RECIP_L[16:0];

   // hour = (tod >> 4) / 225 for 13-bit operands
   localparam int HOUR_SHIFT = 21;
   localparam longint unsigned HOUR_RECIP_L = ((64'd1 << HOUR_SHIFT) + 64'd224) / 64'd225;
   localparam logic [13:0] HOUR_RECIP = HOUR_RECIP_L[13:0];

   // minutes of day = (tod >> 2) / 15 for 15-bit operands
   localparam int MIN_SHIFT = 19;
   localparam longint unsigned MIN_RECIP_L = ((64'd1 << MIN_SHIFT) + 64'd14) / 64'd15;
   localparam logic [15:0] MIN_RECIP = MIN_RECIP_L[15:0];

   localparam logic [9:0]  DAY_DIV    = 10'd675;
   localparam logic [10:0] CYCLE_DAYS = 11'd1461;
   localparam logic [10:0] YEAR3_DAY  = 11'd1096;
   localparam logic [10:0] YEAR2_DAY  = 11'd730;
   localparam logic [10:0] YEAR1_DAY  = 11'd365;
   localparam logic [7:0]  YEAR_BASE  = 8'd70;

   // day of year on which each month starts, common year
   localparam logic [8:0] MONTH_START [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // two packed bcd digits of a value below 100
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [13:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 14'(v) * 14'd103;
      tens = prod[13:10];
      ones = v - 7'(tens) * 7'd10;
      return {tens, ones[3:0]};
   endfunction

endpackage

/* sv/epoch_seconds_to_bcd_datetime.sv */
`timescale 1ns / 1ps
// seconds since 1970-01-01 to packed bcd year, month, day, hour, minute, second
// depends on esbd_pkg

// Converts an unsigned 32-bit seconds count since 1970-01-01 00:00:00 into
// packed BCD year (modulo 100), month, day, hour, minute and second. Inputs
// after 2099-12-31 23:59:59 return all-zero fields with out_of_range set.
// The block is a five-register pipeline: input register, three stages of
// constant-reciprocal multiplies (seconds to days, days to four-year cycles
// and time of day to hours and minutes, then the remainders), and the result
// register after the month lookup and BCD packing. rsp_valid rises once a req
// has passed all five registers; throughput is one transfer per cycle when unstalled.
// Every stage holds while the stage after it is full and stalled, so empty
// stages keep taking new inputs while a result waits on rsp_stall.
module epoch_seconds_to_bcd_datetime (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [esbd_pkg::EPOCH_W-1:0] req_epoch_seconds,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_year_bcd,
   output logic [4:0]                   rsp_month_bcd,
   output logic [5:0]                   rsp_day_bcd,
   output logic [5:0]                   rsp_hour_bcd,
   output logic [6:0]                   rsp_minute_bcd,
   output logic [6:0]                   rsp_second_bcd,
   output logic                         rsp_out_of_range
);
   import esbd_pkg::*;

   // stage valids and ready chain
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, out_vld_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, out_rdy;

   // stage 1: input register
   logic [EPOCH_W-1:0] s1_secs_ff;
   logic               s1_oor_in, s1_oor_ff;

   // stage 2
   logic [50:0]        s1_day_prod;
   logic [DAYS_W-1:0]  s2_days_in, s2_days_ff;
   logic [6:0]         s2_low_ff;
   logic [24:0]        s2_hi_ff;
   logic               s2_oor_ff;

   // stage 3
   logic [25:0]        s2_day_mul;
   logic [24:0]        s2_rem_full;
   logic [TOD_W-1:0]   s3_tod_in, s3_tod_ff;
   logic [32:0]        s2_cyc_prod;
   logic [5:0]         s3_cyc_in, s3_cyc_ff;
   logic [DAYS_W-1:0]  s3_days_ff;
   logic               s3_oor_ff;

   // stage 4
   logic [16:0]        s3_cyc_days;
   logic [10:0]        s4_doy_in, s4_doy_ff;
   logic [26:0]        s3_hour_prod;
   logic [4:0]         s4_hour_in, s4_hour_ff;
   logic [30:0]        s3_min_prod;
   logic [10:0]        s4_mtot_in, s4_mtot_ff;
   logic [5:0]         s4_cyc_ff;
   logic [TOD_W-1:0]   s4_tod_ff;
   logic               s4_oor_ff;

   // calendar fields after stage 4
   logic [8:0]         cal_doy;
   logic [1:0]         cal_yoff;
   logic               cal_leap;
   logic [7:0]         cal_year_raw;
   logic [6:0]         cal_year;
   logic [3:0]         cal_month;
   logic [4:0]         cal_day;
   logic [5:0]         cal_minute;
   logic [5:0]         cal_second;

   // result register
   logic [7:0]         year_bcd_in, year_bcd_ff;
   logic [4:0]         month_bcd_in, month_bcd_ff;
   logic [5:0]         day_bcd_in, day_bcd_ff;
   logic [5:0]         hour_bcd_in, hour_bcd_ff;
   logic [6:0]         minute_bcd_in, minute_bcd_ff;
   logic [6:0]         second_bcd_in, second_bcd_ff;
   logic               oor_ff;

   assign out_rdy = !out_vld_ff || !rsp_stall;
   assign s4_rdy  = !s4_vld_ff || out_rdy;
   assign s3_rdy  = !s3_vld_ff || s4_rdy;
   assign s2_rdy  = !s2_vld_ff || s3_rdy;
   assign s1_rdy  = !s1_vld_ff || s2_rdy;
   assign req_stall = !s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_vld_ff <= req_valid;
         if (s2_rdy) s2_vld_ff <= s1_vld_ff;
         if (s3_rdy) s3_vld_ff <= s2_vld_ff;
         if (s4_rdy) s4_vld_ff <= s3_vld_ff;
         if (out_rdy) out_vld_ff <= s4_vld_ff;
      end
   end

   // stage 1 -> 2: days = secs / 86400 as (secs >> 7) / 675
   assign s1_oor_in   = (req_epoch_seconds >= LIMIT_SECONDS);
   assign s1_day_prod = 51'(s1_secs_ff[31:7]) * 51'(DAY_RECIP);
   assign s2_days_in  = s1_day_prod[50:DAY_SHIFT];

   // stage 2 -> 3: time of day from the remainder, four-year cycle count
   assign s2_day_mul  = 26'(s2_days_ff) * 26'(DAY_DIV);
   assign s2_rem_full = s2_hi_ff - s2_day_mul[24:0];
   assign s3_tod_in   = {s2_rem_full[9:0], s2_low_ff};
   assign s2_cyc_prod = 33'(s2_days_ff) * 33'(CYC_RECIP);
   assign s3_cyc_in   = s2_cyc_prod[32:CYC_SHIFT];

   // stage 3 -> 4: day within cycle, hour and minute of day
   assign s3_cyc_days  = 17'(s3_cyc_ff) * 17'(CYCLE_DAYS);
   assign s4_doy_in    = 11'(17'(s3_days_ff) - s3_cyc_days);
   assign s3_hour_prod = 27'(s3_tod_ff[16:4]) * 27'(HOUR_RECIP);
   assign s4_hour_in   = s3_hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
   assign s3_min_prod  = 31'(s3_tod_ff[16:2]) * 31'(MIN_RECIP);
   assign s4_mtot_in   = s3_min_prod[MIN_SHIFT+10:MIN_SHIFT];

   always_ff @(posedge clock) begin
      if (s1_rdy && req_valid) begin
         s1_secs_ff <= req_epoch_seconds;
         s1_oor_ff  <= s1_oor_in;
      end
      if (s2_rdy) begin
         s2_days_ff <= s2_days_in;
         s2_hi_ff   <= s1_secs_ff[31:7];
         s2_low_ff  <= s1_secs_ff[6:0];
         s2_oor_ff  <= s1_oor_ff;
      end
      if (s3_rdy) begin
         s3_tod_ff  <= s3_tod_in;
         s3_cyc_ff  <= s3_cyc_in;
         s3_days_ff <= s2_days_ff;
         s3_oor_ff  <= s2_oor_ff;
      end
      if (s4_rdy) begin
         s4_doy_ff  <= s4_doy_in;
         s4_hour_ff <= s4_hour_in;
         s4_mtot_ff <= s4_mtot_in;
         s4_cyc_ff  <= s3_cyc_ff;
         s4_tod_ff  <= s3_tod_ff;
         s4_oor_ff  <= s3_oor_ff;
      end
   end

   // year within the cycle; third year is the leap year
   always_comb begin
      cal_leap = 1'b0;
      if (s4_doy_ff >= YEAR3_DAY) begin
         cal_doy  = 9'(s4_doy_ff - YEAR3_DAY);
         cal_yoff = 2'd3;
      end else if (s4_doy_ff >= YEAR2_DAY) begin
         cal_doy  = 9'(s4_doy_ff - YEAR2_DAY);
         cal_yoff = 2'd2;
         cal_leap = 1'b1;
      end else if (s4_doy_ff >= YEAR1_DAY) begin
         cal_doy  = 9'(s4_doy_ff - YEAR1_DAY);
         cal_yoff = 2'd1;
      end else begin
         cal_doy  = 9'(s4_doy_ff);
         cal_yoff = 2'd0;
      end
   end

   always_comb begin
      cal_year_raw = YEAR_BASE + {s4_cyc_ff, 2'b00} + 8'(cal_yoff);
      if (cal_year_raw >= 8'd200) begin
         cal_year = 7'(cal_year_raw - 8'd200);
      end else if (cal_year_raw >= 8'd100) begin
         cal_year = 7'(cal_year_raw - 8'd100);
      end else begin
         cal_year = cal_year_raw[6:0];
      end
   end

   // last month whose start is not past the day; leap day counts from march
   always_comb begin
      logic [8:0] start;
      cal_month = 4'd1;
      cal_day   = 5'(cal_doy + 9'd1);
      for (int m = 1; m < 12; m++) begin
         start = MONTH_START[m] + ((m >= 2) ? 9'(cal_leap) : 9'd0);
         if (cal_doy >= start) begin
            cal_month = 4'(m + 1);
            cal_day   = 5'(cal_doy - start + 9'd1);
         end
      end
   end

   assign cal_second = 6'(s4_tod_ff - 17'(s4_mtot_ff) * 17'd60);
   assign cal_minute = 6'(s4_mtot_ff - 11'(s4_hour_ff) * 11'd60);

   always_comb begin
      logic [7:0] mon_b, day_b, hour_b, min_b, sec_b;
      mon_b  = to_bcd(7'(cal_month));
      day_b  = to_bcd(7'(cal_day));
      hour_b = to_bcd(7'(s4_hour_ff));
      min_b  = to_bcd(7'(cal_minute));
      sec_b  = to_bcd(7'(cal_second));
      year_bcd_in   = to_bcd(cal_year);
      month_bcd_in  = mon_b[4:0];
      day_bcd_in    = day_b[5:0];
      hour_bcd_in   = hour_b[5:0];
      minute_bcd_in = min_b[6:0];
      second_bcd_in = sec_b[6:0];
      if (s4_oor_ff) begin
         year_bcd_in   = '0;
         month_bcd_in  = '0;
         day_bcd_in    = '0;
         hour_bcd_in   = '0;
         minute_bcd_in = '0;
         second_bcd_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         year_bcd_ff   <= year_bcd_in;
         month_bcd_ff  <= month_bcd_in;
         day_bcd_ff    <= day_bcd_in;
         hour_bcd_ff   <= hour_bcd_in;
         minute_bcd_ff <= minute_bcd_in;
         second_bcd_ff <= second_bcd_in;
         oor_ff        <= s4_oor_ff;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_year_bcd     = year_bcd_ff;
   assign rsp_month_bcd    = month_bcd_ff;
   assign rsp_day_bcd      = day_bcd_ff;
   assign rsp_hour_bcd     = hour_bcd_ff;
   assign rsp_minute_bcd   = minute_bcd_ff;
   assign rsp_second_bcd   = second_bcd_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

/* sv/esbd_checker.sv */
`timescale 1ns / 1ps
// port-level checks for epoch_seconds_to_bcd_datetime, attached by bind
// no package dependencies

module esbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_year_bcd,
   input logic [4:0]  rsp_month_bcd,
   input logic [5:0]  rsp_day_bcd,
   input logic [5:0]  rsp_hour_bcd,
   input logic [6:0]  rsp_minute_bcd,
   input logic [6:0]  rsp_second_bcd,
   input logic        rsp_out_of_range
);

   // a stalled result transfer keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_year_bcd)
         && $stable(rsp_month_bcd) && $stable(rsp_day_bcd)
         && $stable(rsp_hour_bcd) && $stable(rsp_minute_bcd)
         && $stable(rsp_second_bcd) && $stable(rsp_out_of_range))
      else $error("rsp payload changed while stalled");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set right after reset");

   // beyond-range results carry all-zero fields
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_year_bcd == 8'h00
         && rsp_month_bcd == 5'h00 && rsp_day_bcd == 6'h00
         && rsp_hour_bcd == 6'h00 && rsp_minute_bcd == 7'h00
         && rsp_second_bcd == 7'h00)
      else $error("out of range result with nonzero fields");

   // in-range month and day are never zero, and month is at most 12
   a_date_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range |-> rsp_month_bcd != 5'h00
         && rsp_day_bcd != 6'h00 && rsp_month_bcd <= 5'h12)
      else $error("in range result with bad month or day");

   // time of day digits stay in range
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range |-> rsp_hour_bcd <= 6'h23
         && rsp_minute_bcd <= 7'h59 && rsp_second_bcd <= 7'h59
         && rsp_minute_bcd[3:0] <= 4'd9 && rsp_second_bcd[3:0] <= 4'd9)
      else $error("time of day out of range");

endmodule

bind epoch_seconds_to_bcd_datetime esbd_checker u_esbd_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// testbench for epoch_seconds_to_bcd_datetime: predicts each calendar result from the
// timestamp and checks every transfer field by field; depends on esbd_pkg and the dut

module testbench;

   localparam int unsigned SECS_PER_DAY    = 86400;
   localparam int unsigned CYCLE_DAYS      = 1461;
   localparam int unsigned FOURTH_YEAR_DAY = 1096;
   localparam int unsigned LEAP_YEAR_DAY   = 730;
   localparam int unsigned SECOND_YEAR_DAY = 365;
   localparam int unsigned EPOCH_YEAR      = 1970;
   localparam int unsigned LAST_DAY        = 47481;   // 2099-12-31 as a day count
   localparam int unsigned STALL_LIMIT     = 2000;
   localparam int unsigned LONG_HOLD       = 300;
   localparam int unsigned SETTLE_CYCLES   = 20;

   typedef struct packed {
      logic [7:0] year;
      logic [4:0] month;
      logic [5:0] day;
      logic [5:0] hour;
      logic [6:0] minute;
      logic [6:0] second;
      logic       out_of_range;
   } datetime_type;

   typedef struct {
      logic [31:0]  stamp;
      datetime_type want;
   } awaited_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [esbd_pkg::EPOCH_W-1:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_year_bcd;
   logic [4:0]  rsp_month_bcd;
   logic [5:0]  rsp_day_bcd;
   logic [5:0]  rsp_hour_bcd;
   logic [6:0]  rsp_minute_bcd;
   logic [6:0]  rsp_second_bcd;
   logic        rsp_out_of_range;

   logic [31:0] stamps_to_send[$];
   awaited_type awaited_dates[$];
   int unsigned month_first[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   bit          req_taken = 1'b0;
   bit          idle_on = 1'b1;
   bit          begin_hold = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned hold_left = 0;
   int unsigned sent_count = 0;
   int unsigned taken_count = 0;
   int unsigned checked_count = 0;
   int unsigned late_count = 0;
   int unsigned leap_day_count = 0;
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;

   epoch_seconds_to_bcd_datetime dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_epoch_seconds(req_epoch_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_year_bcd     (rsp_year_bcd),
      .rsp_month_bcd    (rsp_month_bcd),
      .rsp_day_bcd      (rsp_day_bcd),
      .rsp_hour_bcd     (rsp_hour_bcd),
      .rsp_minute_bcd   (rsp_minute_bcd),
      .rsp_second_bcd   (rsp_second_bcd),
      .rsp_out_of_range (rsp_out_of_range)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] two_digit_bcd(input int unsigned v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function automatic datetime_type predict_datetime(input logic [31:0] secs);
      datetime_type r;
      int unsigned  days, tod, yr, doy, mon, dom, first;
      int unsigned  leap;
      r = '0;
      if (secs >= esbd_pkg::LIMIT_SECONDS) begin
         r.out_of_range = 1'b1;
         return r;
      end
      days = secs / SECS_PER_DAY;
      tod  = secs % SECS_PER_DAY;
      yr   = (days / CYCLE_DAYS) * 4;
      doy  = days % CYCLE_DAYS;
      leap = 0;
      if (doy >= FOURTH_YEAR_DAY) begin
         doy = doy - FOURTH_YEAR_DAY;
         yr  = yr + 3;
      end else if (doy >= LEAP_YEAR_DAY) begin
         doy  = doy - LEAP_YEAR_DAY;
         yr   = yr + 2;
         leap = 1;
      end else if (doy >= SECOND_YEAR_DAY) begin
         doy = doy - SECOND_YEAR_DAY;
         yr  = yr + 1;
      end
      yr = yr + EPOCH_YEAR;
      // leap day shifts month starts only from march on; starts rise so the last hit wins
      mon = 1;
      dom = doy + 1;
      for (int m = 2; m <= 12; m++) begin
         first = month_first[m-1] + ((m >= 3) ? leap : 0);
         if (doy >= first) begin
            mon = m;
            dom = doy - first + 1;
         end
      end
      r.year   = two_digit_bcd(yr % 100);
      r.month  = 5'(two_digit_bcd(mon));
      r.day    = 6'(two_digit_bcd(dom));
      r.hour   = 6'(two_digit_bcd(tod / 3600));
      r.minute = 7'(two_digit_bcd((tod / 60) % 60));
      r.second = 7'(two_digit_bcd(tod % 60));
      return r;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] stamp,
                                input logic [7:0] got, input logic [7:0] want);
      error_count++;
      $display("%0t mismatch %s for %0d: got %h want %h", $realtime, what, stamp, got, want);
   endtask

   // driver: a stalled transfer holds its payload until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (stamps_to_send.size() != 0 && !(idle_on && $urandom_range(99) < 29)) begin
         req_valid         <= 1'b1;
         req_epoch_seconds <= stamps_to_send.pop_front();
         sent_count++;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver stall, with one long hold-off counted here
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (begin_hold && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 29);
      end
   end

   // monitor: record accepted timestamps, check each result transfer
   always @(posedge clock) begin
      datetime_type got;
      awaited_type  head;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         head.stamp = req_epoch_seconds;
         head.want  = predict_datetime(req_epoch_seconds);
         awaited_dates.push_back(head);
         taken_count++;
         if (head.want.out_of_range)
            late_count++;
         if (head.want.month == 5'h02 && head.want.day == 6'h29)
            leap_day_count++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_year_bcd, rsp_month_bcd, rsp_day_bcd, rsp_hour_bcd,
                 rsp_minute_bcd, rsp_second_bcd, rsp_out_of_range};
         if (awaited_dates.size() == 0) begin
            note_mismatch("unexpected result", 32'd0, got.year, 8'd0);
         end else begin
            head = awaited_dates.pop_front();
            checked_count++;
            if (got.year !== head.want.year)
               note_mismatch("year", head.stamp, got.year, head.want.year);
            if (got.month !== head.want.month)
               note_mismatch("month", head.stamp, 8'(got.month), 8'(head.want.month));
            if (got.day !== head.want.day)
               note_mismatch("day", head.stamp, 8'(got.day), 8'(head.want.day));
            if (got.hour !== head.want.hour)
               note_mismatch("hour", head.stamp, 8'(got.hour), 8'(head.want.hour));
            if (got.minute !== head.want.minute)
               note_mismatch("minute", head.stamp, 8'(got.minute), 8'(head.want.minute));
            if (got.second !== head.want.second)
               note_mismatch("second", head.stamp, 8'(got.second), 8'(head.want.second));
            if (got.out_of_range !== head.want.out_of_range)
               note_mismatch("out_of_range", head.stamp, 8'(got.out_of_range),
                             8'(head.want.out_of_range));
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic drain();
      while (stamps_to_send.size() != 0 || taken_count != sent_count ||
             awaited_dates.size() != 0)
         @(posedge clock);
   endtask

   task automatic offer_random(input int unsigned count);
      int unsigned pick, stamp;
      for (int unsigned i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            stamp = $urandom_range(esbd_pkg::LIMIT_SECONDS - 1, 0);
         end else if (pick < 80) begin
            // a few seconds either side of midnight, which also hits month and year edges
            stamp = $urandom_range(LAST_DAY, 0) * SECS_PER_DAY;
            if ($urandom_range(1))
               stamp = stamp + $urandom_range(2);
            else
               stamp = stamp + SECS_PER_DAY - 1 - $urandom_range(2);
         end else if (pick < 90) begin
            stamp = $urandom;
         end else begin
            stamp = esbd_pkg::LIMIT_SECONDS - 1000 + $urandom_range(1999);
         end
         stamps_to_send.push_back(stamp);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // field extremes and calendar edges, leap year 1972 in detail
      stamps_to_send = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                         32'd31535999, 32'd31536000, 32'd65664000, 32'd65750400,
                         32'd68169599, 32'd68169600, 32'd68255999, 32'd68256000,
                         32'd94694399, 32'd94694400, 32'd946684799, 32'd946684800,
                         32'd2147483647, 32'd2147483648, 32'd4102444799,
                         32'd4102444800, 32'hFFFF_FFFF, 32'hAAAA_5555};
      drain();

      // receiver holds off while timestamps keep coming, so the pipeline backs up
      begin_hold = 1'b1;
      offer_random(100);
      drain();

      offer_random(500);
      drain();
      // no idling on either side for a stretch
      idle_on = 1'b0;
      offer_random(500);
      drain();
      idle_on = 1'b1;
      offer_random(900);
      drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("tb: %0d timestamps sent, %0d results checked", taken_count, checked_count);
      $display("tb: %0d past the 2099 limit, %0d on a february 29th", late_count,
               leap_day_count);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
